### src/mcrc_pkg.sv
package mcrc_pkg;

    localparam int CODE_W            = 15;
    localparam int LEN_W             = 3;
    localparam int DEF_MAX_MOTIF_LEN = 6;
    localparam int RECIP_SHIFT       = 18;
    localparam int RECIP_W           = 19;

    // Offset of the first code of each motif length; entry seven is the top threshold.
    function automatic logic [CODE_W-1:0] motif_base(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] b;
        unique case (len)
            3'd0:    b = 15'd0;
            3'd1:    b = 15'd0;
            3'd2:    b = 15'd4;
            3'd3:    b = 15'd36;
            3'd4:    b = 15'd228;
            3'd5:    b = 15'd1252;
            3'd6:    b = 15'd6372;
            3'd7:    b = 15'd30948;
            default: b = 15'd0;
        endcase
        return b;
    endfunction

    // Rounded-up reciprocal of the length, scaled by two to the RECIP_SHIFT.
    function automatic logic [RECIP_W-1:0] len_recip(input logic [LEN_W-1:0] len);
        logic [RECIP_W-1:0] r;
        unique case (len)
            3'd1:    r = 19'd262144;
            3'd2:    r = 19'd131072;
            3'd3:    r = 19'd87382;
            3'd4:    r = 19'd65536;
            3'd5:    r = 19'd52429;
            3'd6:    r = 19'd43691;
            default: r = 19'd0;
        endcase
        return r;
    endfunction

endpackage

### src/motif_code_reverse_complement_top.sv
// Accepts one code per cycle while the result is not stalled, through four register stages
// (classify, reciprocal multiply, remainder and base shuffle, re-encode).
// A stalled result holds every stage behind it; a stage with no valid beat still takes one.
// Reset clears the stage valid bits asynchronously; the data registers are not reset.
module motif_code_reverse_complement_top
    import mcrc_pkg::*;
#(
    parameter int MAX_MOTIF_LEN = DEF_MAX_MOTIF_LEN
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              code_valid,
    output logic              code_ready,
    input  logic [CODE_W-1:0] in_code,
    output logic              rc_valid,
    input  logic              rc_ready,
    output logic [CODE_W-1:0] rc_code,
    output logic [LEN_W-1:0]  motif_len,
    output logic              out_of_range
);

    localparam int MW    = 2 * MAX_MOTIF_LEN;
    localparam int IDX_W = $clog2(MAX_MOTIF_LEN);
    localparam int PW    = CODE_W + RECIP_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    logic [LEN_W-1:0]  len1_reg, len2_reg, len3_reg;
    logic [CODE_W-1:0] rem1_reg, rem2_reg;
    logic              oor1_reg, oor2_reg, oor3_reg;
    logic [MW-1:0]     q2_reg;
    logic [LEN_W-1:0]  oh3_reg;
    logic [MW-1:0]     fresh3_reg;

    logic [CODE_W-1:0] rc_code_reg;
    logic [LEN_W-1:0]  motif_len_reg;
    logic              oor4_reg;

    logic [LEN_W-1:0]  len1_next;
    logic [CODE_W-1:0] rem1_next;
    logic              oor1_next;
    logic [PW-1:0]     prod2;
    logic [MW-1:0]     q2_next;
    logic [CODE_W-1:0] rem_low;
    logic [LEN_W-1:0]  oh3_next;
    logic [MW-1:0]     fresh3_next;
    logic [CODE_W-1:0] rc_code_next;

    assign adv4       = !v4_reg || rc_ready;
    assign adv3       = !v3_reg || adv4;
    assign adv2       = !v2_reg || adv3;
    assign adv1       = !v1_reg || adv2;
    assign code_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= code_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage one finds the length from the thresholds and strips the length offset.
    always_comb
    begin
        len1_next = 3'd1;
        for (int l = 2; l <= MAX_MOTIF_LEN; l++)
        begin
            if (in_code >= motif_base(LEN_W'(l)))
            begin
                len1_next = LEN_W'(l);
            end
        end
        oor1_next = (in_code >= motif_base(LEN_W'(MAX_MOTIF_LEN + 1)));
        rem1_next = in_code - motif_base(len1_next);
    end

    // Stage two divides by the length through its reciprocal.
    assign prod2   = PW'(rem1_reg) * PW'(len_recip(len1_reg));
    assign q2_next = MW'(prod2 >> RECIP_SHIFT);

    // Stage three recovers the overhang, then rotates, reverses and complements the bases.
    always_comb
    begin
        logic [1:0] pairs [MAX_MOTIF_LEN];
        int         idx;
        rem_low  = rem2_reg - CODE_W'(q2_reg) * CODE_W'(len2_reg);
        oh3_next = rem_low[LEN_W-1:0];
        for (int i = 0; i < MAX_MOTIF_LEN; i++)
        begin
            pairs[i] = q2_reg[2*i +: 2];
        end
        fresh3_next = '0;
        for (int j = 0; j < MAX_MOTIF_LEN; j++)
        begin
            idx = 2 * int'(len2_reg) - 1 - j - int'(oh3_next);
            if (idx >= int'(len2_reg))
            begin
                idx = idx - int'(len2_reg);
            end
            if (j < int'(len2_reg))
            begin
                fresh3_next[2*j +: 2] = ~pairs[IDX_W'(idx)];
            end
        end
    end

    // Stage four re-encodes with the same length and overhang.
    assign rc_code_next = motif_base(len3_reg)
                        + CODE_W'(fresh3_reg) * CODE_W'(len3_reg)
                        + CODE_W'(oh3_reg);

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            len1_reg <= len1_next;
            rem1_reg <= rem1_next;
            oor1_reg <= oor1_next;
        end
        if (adv2)
        begin
            len2_reg <= len1_reg;
            rem2_reg <= rem1_reg;
            oor2_reg <= oor1_reg;
            q2_reg   <= q2_next;
        end
        if (adv3)
        begin
            len3_reg   <= len2_reg;
            oor3_reg   <= oor2_reg;
            oh3_reg    <= oh3_next;
            fresh3_reg <= fresh3_next;
        end
        if (adv4)
        begin
            oor4_reg      <= oor3_reg;
            rc_code_reg   <= oor3_reg ? '0 : rc_code_next;
            motif_len_reg <= oor3_reg ? '0 : len3_reg;
        end
    end

    assign rc_valid     = v4_reg;
    assign rc_code      = rc_code_reg;
    assign motif_len    = motif_len_reg;
    assign out_of_range = oor4_reg;

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rc_valid && out_of_range |-> rc_code == '0 && motif_len == '0)
        else $error("out-of-range result carries nonzero fields");

    a_len_span: assert property (@(posedge clk) disable iff (!rst_n)
        rc_valid && !out_of_range |-> motif_len != '0 && motif_len <= LEN_W'(MAX_MOTIF_LEN))
        else $error("decoded length outside the supported span");

    a_oh_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !oor3_reg |-> oh3_reg < len3_reg)
        else $error("overhang not below the motif length");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !(v1_reg && v2_reg && v3_reg && v4_reg) |-> code_ready)
        else $error("input held off while the pipeline has a free stage");

endmodule
